[rtl/core/silu_activation_unit_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef SILU_ACTIVATION_UNIT_MACROS_SVH
`define SILU_ACTIVATION_UNIT_MACROS_SVH

// The condition implies the property in the same cycle.
`define SILU_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// The condition implies the property in the next cycle.
`define SILU_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/silu_pkg.sv]
`default_nettype none
package silu_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               in_last;
  } silu_in_t;

  typedef struct packed {
    logic signed [15:0] activation;
    logic               out_last;
  } silu_out_t;

  // Reduced argument of the exponential: remainder r in Q.30 and exponent k.
  typedef struct packed {
    logic signed [31:0] r;
    logic signed [7:0]  k;
    logic signed [15:0] x;
    logic               last;
  } silu_red_t;

  // exp(r) in Q.30, never negative, together with the exponent k.
  typedef struct packed {
    logic [30:0]        er;
    logic signed [7:0]  k;
    logic signed [15:0] x;
    logic               last;
  } silu_exp_t;

  // Raw quotient of the reciprocal and a flag that forces sigmoid to zero.
  typedef struct packed {
    logic [16:0]        quo;
    logic               zero;
    logic signed [15:0] x;
    logic               last;
  } silu_sig_t;

  localparam logic signed [16:0] ARG_CLAMP   = 17'sd22528;
  localparam logic [30:0]        INV_LN2_Q30 = 31'd1549082005;
  localparam logic [29:0]        LN2_Q30     = 30'd744261118;
  localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
  localparam logic signed [31:0] C_HALF      = 32'sd536870912;
  localparam logic signed [31:0] C_SIXTH     = 32'sd178956971;
  localparam logic signed [31:0] C_24TH      = 32'sd44739243;
  localparam logic signed [31:0] C_120TH     = 32'sd8947849;
  localparam logic signed [7:0]  K_SIG_ZERO  = 8'sd30;

  localparam int unsigned POLY_STEPS = 5;
  localparam int unsigned DIV_STEPS  = 17;

  // Coefficients added after each Horner multiply, highest order first.
  localparam logic signed [31:0] POLY_ADD [POLY_STEPS] =
    '{C_24TH, C_SIXTH, C_HALF, Q30_ONE, Q30_ONE};

endpackage
`default_nettype wire

[rtl/core/silu_activation_unit.sv]
// SiLU activation unit: activation = x * sigmoid(x) on signed Q8.8 samples.
// Input channel: in_valid_i / in_ready_o with in_data_i (sample, in_last).
// Output channel: out_valid_o / out_ready_i with out_data_o (activation,
// out_last). A request moves when valid and ready are both high.
// A request passes through the reduce, poly, recip and scale stages on its
// way to the output. Throughput is one request per cycle while the output
// is not stalled; every stage is a register with a valid bit, and a stage takes new
// data whenever it is empty or the stage after it moves on.
// The longest stages are the 32x32 Horner multiplies and the 63-bit compare
// and subtract of each of the 17 restoring division steps.
// While the receiver stalls, the result stays on out_data_o and the pipeline
// keeps accepting requests until every stage holds one; empty stages are
// filled first, so nothing is dropped or repeated.
// Reset clears all valid bits; the block holds no other state and is ready
// right after reset. The last mark travels alongside each sample.
`default_nettype none
module silu_activation_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire silu_pkg::silu_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output silu_pkg::silu_out_t     out_data_o
);
  import silu_pkg::*;

  // Range reduction: clamp -x to +-88, k = round(-x/ln2), r = -x - k*ln2.
  logic      red_valid;
  logic      red_ready;
  silu_red_t red_data;

  // exp(r) from a fifth-order Taylor polynomial in Q.30.
  logic      exp_valid;
  logic      exp_ready;
  silu_exp_t exp_data;

  // Sigmoid as a reciprocal of 1 + exp(r) * 2^k.
  logic      sig_valid;
  logic      sig_ready;
  silu_sig_t sig_data;

  silu_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .out_data_o  (red_data)
  );

  silu_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .in_data_i   (red_data),
    .out_valid_o (exp_valid),
    .out_ready_i (exp_ready),
    .out_data_o  (exp_data)
  );

  silu_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (exp_valid),
    .in_ready_o  (exp_ready),
    .in_data_i   (exp_data),
    .out_valid_o (sig_valid),
    .out_ready_i (sig_ready),
    .out_data_o  (sig_data)
  );

  // Saturates sigmoid to Q0.16, multiplies by the raw sample and rounds.
  silu_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sig_valid),
    .in_ready_o  (sig_ready),
    .in_data_i   (sig_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[rtl/core/silu_reduce.sv]
`default_nettype none
module silu_reduce (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire silu_pkg::silu_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output silu_pkg::silu_red_t      out_data_o
);
  import silu_pkg::*;

  localparam int unsigned NS = 4;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic signed [15:0] x_q    [NS];
  logic               last_q [NS];
  logic signed [15:0] tc_q   [3];
  logic               neg_q;
  logic [45:0]        pm_q;
  logic signed [7:0]  k_q    [2];
  logic signed [38:0] kl_q;
  logic signed [31:0] r_q;

  logic signed [16:0] t_neg;
  logic signed [15:0] tc_d;
  logic [14:0]        tmag;
  logic [46:0]        kround;
  logic [7:0]         kmag;
  logic signed [39:0] rdiff;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  always_comb begin
    t_neg = -$signed({in_data_i.sample[15], in_data_i.sample});
    if (t_neg > ARG_CLAMP) begin
      tc_d = ARG_CLAMP[15:0];
    end else if (t_neg < -ARG_CLAMP) begin
      tc_d = 16'(-ARG_CLAMP);
    end else begin
      tc_d = t_neg[15:0];
    end
    tmag   = tc_d[15] ? 15'(-tc_d) : tc_d[14:0];
    kround = {1'b0, pm_q} + (47'd1 << 37);
    kmag   = kround[45:38];
    rdiff  = (40'(tc_q[2]) <<< 22) - 40'(kl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q[0]    <= in_data_i.sample;
      last_q[0] <= in_data_i.in_last;
      tc_q[0]   <= tc_d;
      neg_q     <= tc_d[15];
      pm_q      <= 46'(tmag) * 46'(INV_LN2_Q30);
    end
    if (rdy[1]) begin
      x_q[1]    <= x_q[0];
      last_q[1] <= last_q[0];
      tc_q[1]   <= tc_q[0];
      k_q[0]    <= neg_q ? 8'(-kmag) : kmag;
    end
    if (rdy[2]) begin
      x_q[2]    <= x_q[1];
      last_q[2] <= last_q[1];
      tc_q[2]   <= tc_q[1];
      k_q[1]    <= k_q[0];
      kl_q      <= 39'(k_q[0]) * 39'($signed({1'b0, LN2_Q30}));
    end
    if (rdy[3]) begin
      x_q[3]    <= x_q[2];
      last_q[3] <= last_q[2];
      r_q       <= rdiff[31:0];
    end
  end

  // k of the last stage is held one stage behind; copy it along with r.
  logic signed [7:0] k3_q;
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      k3_q <= k_q[1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = '{r: r_q, k: k3_q, x: x_q[NS-1], last: last_q[NS-1]};

endmodule
`default_nettype wire

[rtl/core/silu_poly.sv]
`default_nettype none
module silu_poly (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire silu_pkg::silu_red_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output silu_pkg::silu_exp_t      out_data_o
);
  import silu_pkg::*;

  // Each Horner step is a multiply stage followed by a round-and-add stage.
  localparam int unsigned NS = 2 * POLY_STEPS;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic signed [31:0] r_q    [NS];
  logic signed [7:0]  k_q    [NS];
  logic signed [15:0] x_q    [NS];
  logic               last_q [NS];
  logic signed [63:0] prod_q [POLY_STEPS];
  logic signed [31:0] acc_q  [POLY_STEPS];

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
    logic signed [31:0] a_src;
    logic signed [31:0] r_src;
    logic signed [7:0]  k_src;
    logic signed [15:0] x_src;
    logic               last_src;
    logic signed [63:0] rsum;

    if (j == 0) begin : g_first
      assign a_src    = C_120TH;
      assign r_src    = in_data_i.r;
      assign k_src    = in_data_i.k;
      assign x_src    = in_data_i.x;
      assign last_src = in_data_i.last;
    end else begin : g_next
      assign a_src    = acc_q[j-1];
      assign r_src    = r_q[2*j-1];
      assign k_src    = k_q[2*j-1];
      assign x_src    = x_q[2*j-1];
      assign last_src = last_q[2*j-1];
    end

    // Round to nearest with ties toward plus infinity, then drop 30 bits.
    assign rsum = prod_q[j] + 64'sd536870912;

    always_ff @(posedge clk_i) begin
      if (rdy[2*j]) begin
        prod_q[j]   <= 64'(a_src) * 64'(r_src);
        r_q[2*j]    <= r_src;
        k_q[2*j]    <= k_src;
        x_q[2*j]    <= x_src;
        last_q[2*j] <= last_src;
      end
      if (rdy[2*j+1]) begin
        acc_q[j]      <= rsum[61:30] + POLY_ADD[j];
        r_q[2*j+1]    <= r_q[2*j];
        k_q[2*j+1]    <= k_q[2*j];
        x_q[2*j+1]    <= x_q[2*j];
        last_q[2*j+1] <= last_q[2*j];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = '{
    er:   acc_q[POLY_STEPS-1][31] ? 31'd0 : acc_q[POLY_STEPS-1][30:0],
    k:    k_q[NS-1],
    x:    x_q[NS-1],
    last: last_q[NS-1]
  };

endmodule
`default_nettype wire

[rtl/core/silu_recip.sv]
`default_nettype none
module silu_recip (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire silu_pkg::silu_exp_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output silu_pkg::silu_sig_t      out_data_o
);
  import silu_pkg::*;

  // One scaling stage, one stage that forms divisor and dividend, then one
  // restoring division step per quotient bit.
  localparam int unsigned NS = DIV_STEPS + 2;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic               zero_q [NS];
  logic signed [15:0] x_q    [NS];
  logic               last_q [NS];
  logic [60:0]        e_q;
  logic [61:0]        d1_q;
  logic [61:0]        rem1_q;
  logic [16:0]        nlow1_q;
  logic [61:0]        d_q    [DIV_STEPS];
  logic [61:0]        rem_q  [DIV_STEPS];
  logic [16:0]        nlow_q [DIV_STEPS];
  logic [16:0]        quo_q  [DIV_STEPS];

  logic [60:0] e_d;
  logic [7:0]  nsh;
  logic [61:0] dv;
  logic [61:0] nv;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  always_comb begin
    nsh = 8'(-in_data_i.k);
    if (in_data_i.k > K_SIG_ZERO) begin
      e_d = '0;
    end else if (!in_data_i.k[7]) begin
      e_d = 61'(in_data_i.er) << in_data_i.k[4:0];
    end else if (nsh >= 8'd31) begin
      e_d = '0;
    end else begin
      e_d = 61'(in_data_i.er >> nsh[4:0]);
    end
    dv = (62'd1 << 30) + 62'(e_q);
    nv = (62'd1 << 46) + (dv >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      e_q       <= e_d;
      zero_q[0] <= in_data_i.k > K_SIG_ZERO;
      x_q[0]    <= in_data_i.x;
      last_q[0] <= in_data_i.last;
    end
    if (rdy[1]) begin
      d1_q      <= dv;
      rem1_q    <= 62'(nv[61:17]);
      nlow1_q   <= nv[16:0];
      zero_q[1] <= zero_q[0];
      x_q[1]    <= x_q[0];
      last_q[1] <= last_q[0];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [61:0] d_src;
    logic [61:0] rem_src;
    logic [16:0] nlow_src;
    logic [16:0] quo_src;
    logic [62:0] rs;
    logic [62:0] diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign d_src    = d1_q;
      assign rem_src  = rem1_q;
      assign nlow_src = nlow1_q;
      assign quo_src  = '0;
    end else begin : g_next
      assign d_src    = d_q[j-1];
      assign rem_src  = rem_q[j-1];
      assign nlow_src = nlow_q[j-1];
      assign quo_src  = quo_q[j-1];
    end

    assign rs   = {rem_src, nlow_src[DIV_STEPS-1-j]};
    assign ge   = rs >= {1'b0, d_src};
    assign diff = rs - {1'b0, d_src};

    always_ff @(posedge clk_i) begin
      if (rdy[j+2]) begin
        d_q[j]      <= d_src;
        rem_q[j]    <= ge ? diff[61:0] : rs[61:0];
        nlow_q[j]   <= nlow_src;
        quo_q[j]    <= {quo_src[15:0], ge};
        zero_q[j+2] <= zero_q[j+1];
        x_q[j+2]    <= x_q[j+1];
        last_q[j+2] <= last_q[j+1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = '{
    quo:  quo_q[DIV_STEPS-1],
    zero: zero_q[NS-1],
    x:    x_q[NS-1],
    last: last_q[NS-1]
  };

endmodule
`default_nettype wire

[rtl/core/silu_scale.sv]
`default_nettype none
module silu_scale (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire silu_pkg::silu_sig_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output silu_pkg::silu_out_t      out_data_o
);
  import silu_pkg::*;

  localparam int unsigned NS = 2;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic signed [32:0] prod_q;
  logic               last_q [NS];
  logic signed [15:0] act_q;

  logic [15:0]        sig;
  logic signed [33:0] rsum;
  logic signed [17:0] shv;
  logic signed [15:0] act_d;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  always_comb begin
    if (in_data_i.zero) begin
      sig = '0;
    end else if (in_data_i.quo[16]) begin
      sig = 16'hFFFF;
    end else begin
      sig = in_data_i.quo[15:0];
    end
    rsum = 34'(prod_q) + 34'sd32768;
    shv  = rsum[33:16];
    if (shv > 18'sd32767) begin
      act_d = 16'sh7FFF;
    end else if (shv < -18'sd32768) begin
      act_d = 16'sh8000;
    end else begin
      act_d = shv[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      prod_q    <= 33'(in_data_i.x) * 33'($signed({1'b0, sig}));
      last_q[0] <= in_data_i.last;
    end
    if (rdy[1]) begin
      act_q     <= act_d;
      last_q[1] <= last_q[0];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = '{activation: act_q, out_last: last_q[NS-1]};

endmodule
`default_nettype wire

[rtl/core/silu_activation_unit_checker.sv]
`default_nettype none
`include "silu_activation_unit_macros.svh"
module silu_activation_unit_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire silu_pkg::silu_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire silu_pkg::silu_out_t out_data_o
);
  import silu_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i || (in_data_i.in_last === 1'b0) || 1'b1;

  // A pending result is held until it is taken.
  `SILU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `SILU_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")
  // An empty or draining output stage frees every stage behind it.
  `SILU_ASSERT_SAME(a_ready_flow, in_seen && (out_ready_i || !out_valid_o), in_ready_o,
                    "input stalled with free pipeline")
  // SiLU never falls below about -0.28, so negative results stay small.
  `SILU_ASSERT_SAME(a_neg_bound, out_valid_o && out_data_o.activation[15],
                    out_data_o.activation >= -16'sd80, "negative result out of range")

endmodule

bind silu_activation_unit silu_activation_unit_checker u_silu_chk (.*);
`default_nettype wire

[sim/silu_activation_unit_tb.sv]
`default_nettype none
module silu_activation_unit_tb;
  import silu_pkg::*;

  // The clock runs with a 12 unit period. Inputs are driven on the falling edge
  // and outputs are sampled on the rising edge, so no race can arise.
  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  silu_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  silu_out_t out_data_o;

  silu_activation_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  localparam int PIPE_LATENCY = 35;
  localparam int CYCLE_LIMIT  = 400000;

  silu_out_t pending_acts[$];
  int        fail_count;
  int        cycle_count;
  bit        hold_off;
  bit        stall_enable;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // This is the cycle-level timeout. It runs independently of the stimulus.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // This helper returns floor(v / 2^n) for a signed 64-bit value.
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // SiLU prediction:
  // - Clamp -x to +-88.0 and reduce it by k = round(t/ln2), with ties away from zero.
  // - Evaluate a Horner polynomial in Q.30 for exp(r), then scale by 2^k.
  // - Compute the Q0.16 reciprocal, then multiply by the raw sample.
  function automatic silu_out_t silu_predict(silu_in_t req);
    silu_out_t     res;
    longint        x, t, p, mag, kmag, k, r, er, rd;
    longint        prod;
    longint unsigned e, d, sig;
    x = longint'(req.sample);
    t = -x;
    if (t > 22528) t = 22528;
    if (t < -22528) t = -22528;
    p = t * 64'sd1549082005;
    mag = (p < 0) ? -p : p;
    kmag = (mag + (64'sd1 <<< 37)) >>> 38;
    k = (p < 0) ? -kmag : kmag;
    r = t * 64'sd4194304 - k * 64'sd744261118;
    er = 64'sd8947849;
    er = q30_mul(er, r) + 64'sd44739243;
    er = q30_mul(er, r) + 64'sd178956971;
    er = q30_mul(er, r) + 64'sd536870912;
    er = q30_mul(er, r) + 64'sd1073741824;
    er = q30_mul(er, r) + 64'sd1073741824;
    if (er < 0) er = 0;
    if (k > 127) k = 127;
    if (k < -126) k = -126;
    if (k > 30) begin
      // A very large exponent makes sigmoid smaller than one Q0.16 step.
      sig = 0;
    end else begin
      if (k >= 0) e = longint'(er) << k;
      else if (-k >= 63) e = 0;
      else e = longint'(er) >> (-k);
      d = 64'd1073741824 + e;
      sig = ((64'd1 << 46) + (d >> 1)) / d;
      // When sigmoid rounds to one, it saturates to the largest Q0.16 code.
      if (sig > 65535) sig = 65535;
    end
    prod = floor_shr(x * longint'(sig) + 32768, 16);
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    rd = prod;
    res.activation = rd[15:0];
    res.out_last   = req.in_last;
    return res;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // This task sends one request and waits for the handshake. The expected
  // result is queued as the request is accepted. Valid is dropped only when
  // a gap follows, so back-to-back requests keep it high.
  task automatic send_sample(logic signed [15:0] s, logic l, bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: s, in_last: l};
    do @(posedge clk_i); while (!in_ready_o);
    pending_acts.push_back(silu_predict(in_data_i));
    @(negedge clk_i);
  endtask

  // The receiver's ready signal follows a random stall pattern when stalls are
  // enabled. During a hold-off, ready stays low so that the pipeline fills up.
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (!stall_enable) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < 70);
    end
  end

  // This block compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    silu_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_acts.size() == 0) begin
        $error("unexpected result activation=%0d", out_data_o.activation);
        fail_count++;
      end else begin
        want = pending_acts.pop_front();
        if (out_data_o.activation !== want.activation) begin
          $error("activation mismatch: expected %0d actual %0d",
                 want.activation, out_data_o.activation);
          fail_count++;
        end
        if (out_data_o.out_last !== want.out_last) begin
          $error("out_last mismatch: expected %0b actual %0b",
                 want.out_last, out_data_o.out_last);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [15:0] vals[$];
    vals = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd256, -16'sd256,
             16'sd22528, -16'sd22528, 16'sd22529, -16'sd22529, 16'sd7936,
             -16'sd7936, 16'sd7680, -16'sd7424, 16'sd177, -16'sd177, 16'sd128,
             -16'sd5, 16'sh5555, -16'sh2AAB, 16'sd4096};
    foreach (vals[i]) send_sample(vals[i], i[0], 1'b0);
  endtask

  task automatic test_random_stream(int count);
    int roll;
    logic signed [15:0] s;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      // Most samples lie in the sigmoid's transition zone. The rest are wider or full-range.
      if (roll < 60) s = 16'($urandom_range(0, 6000) - 3000);
      else if (roll < 80) s = 16'($urandom_range(0, 50000) - 25000);
      else s = 16'($urandom());
      send_sample(s, ($urandom_range(0, 7) == 0), 1'b1);
    end
  endtask

  // The receiver holds off while the sender keeps offering
  // back-to-back requests. The block fills up and lowers in_ready_o.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (80) send_sample(16'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
      end
    join
  endtask

  task automatic drain();
    while (pending_acts.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
  endtask

  initial begin
    fail_count   = 0;
    hold_off     = 1'b0;
    stall_enable = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    stall_enable = 1'b1;
    test_random_stream(270);
    test_backpressure();
    stall_enable = 1'b0;
    test_random_stream(270);
    in_valid_i <= 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
